// ----- hdl/alfp_pkg.sv -----
// Shared types, character codes and helper functions for the list field parser.
`timescale 1ns / 1ps

package alfp_pkg;

    // Default width of the number accumulators.
    localparam int VALUE_WIDTH_DEF = 32;

    // Number of result bundles held between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Most results one character can cause.
    localparam int MAX_RESULTS = 4;

    // Character codes the parser looks for.
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Result kinds.
    typedef enum logic [2:0] {
        K_NUMBER  = 3'd0,
        K_RANGE   = 3'd1,
        K_BYTE    = 3'd2,
        K_STR_END = 3'd3,
        K_CLOSED  = 3'd4,
        K_CUT     = 3'd5,
        K_BAILED  = 3'd6,
        K_NO_LIST = 3'd7
    } kind_t;

    // Parser modes.
    typedef enum logic [3:0] {
        M_OPEN,
        M_LIST,
        M_N1D,
        M_N1S,
        M_N2D,
        M_N2S,
        M_STR,
        M_ESC,
        M_HEX1,
        M_SAFT,
        M_SSP,
        M_DONE
    } mode_t;

    // One input transaction.
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_item_t;

    // One result without its end-of-step flag.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] first_value;
        logic [31:0] last_value;
        logic [7:0]  string_byte;
    } result_t;

    // One output transaction.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] first_value;
        logic [31:0] last_value;
        logic [7:0]  string_byte;
        logic        last;
    } out_item_t;

    // All results caused by one character; last_idx is the index of the final one.
    typedef struct packed {
        logic [1:0]                    last_idx;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

    // Builds a result record.
    function automatic result_t mk_result(kind_t k, logic [31:0] a, logic [31:0] b,
                                          logic [7:0] byt);
        result_t r;
        r.kind        = k;
        r.first_value = a;
        r.last_value  = b;
        r.string_byte = byt;
        return r;
    endfunction

    // Decimal digit test.
    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- hdl/at_list_field_parser.sv -----
// A result passes through the bundle queue and then the output stage's held bundle before it reaches the result ports.
// Throughput: one character per cycle while the four-bundle queue has room.
// Results leave at one per cycle while pop is high, so the output stage sets the rate for characters
// that cause more than one result (up to four each).
// Reset: rst_n clears the parser mode, accumulators, queue and output stage at once.
// Top level of the parenthesised list parser for modem response lines.
`timescale 1ns / 1ps

module at_list_field_parser #(
    parameter int VALUE_WIDTH = alfp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  alfp_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output alfp_pkg::out_item_t result
);
    import alfp_pkg::*;

    logic    accept;
    logic    push_q;
    bundle_t wr_bundle;
    bundle_t rd_bundle;
    logic    q_pop;
    logic    q_nonempty;

    assign accept = push && !full;

    // Parser front end.
    alfp_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push_q (push_q),
        .bundle (wr_bundle)
    );

    // Bundle queue.
    alfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push_q),
        .wr_data  (wr_bundle),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (rd_bundle),
        .nonempty (q_nonempty)
    );

    // Output stage.
    alfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (rd_bundle),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- hdl/alfp_front.sv -----
// Parser front end: takes one character per cycle while accept is high and builds the bundle of results it causes.
`timescale 1ns / 1ps

module alfp_front #(
    parameter int VALUE_WIDTH = alfp_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  alfp_pkg::in_item_t item,
    output logic              push_q,
    output alfp_pkg::bundle_t bundle
);
    import alfp_pkg::*;

    localparam int VW = VALUE_WIDTH;

    // Outcome of one dispatch of the character in a given mode.
    typedef struct packed {
        logic          emit;
        result_t       res;
        mode_t         mode;
        logic [VW-1:0] f;
        logic [VW-1:0] s;
        logic [3:0]    h;
        logic          again;
    } pass_t;

    mode_t         mode_reg, mode_next;
    logic [VW-1:0] first_reg, first_next;
    logic [VW-1:0] second_reg, second_next;
    logic [3:0]    held_reg, held_next;

    pass_t p1, p2;
    logic [2:0] res_cnt;

    // Accumulate one decimal digit, wrapping at the accumulator width.
    function automatic logic [VW-1:0] mul10_add(logic [VW-1:0] a, logic [7:0] c);
        return (a << 3) + (a << 1) + VW'(c[3:0]);
    endfunction

    // One dispatch of the character; again asks for a second dispatch in the new mode.
    function automatic pass_t run_pass(mode_t mode, logic [7:0] c, logic [VW-1:0] f,
                                       logic [VW-1:0] s, logic [3:0] h);
        pass_t      p;
        logic [4:0] hx;
        logic       dig;
        p.emit  = 1'b0;
        p.res   = mk_result(K_NUMBER, 32'd0, 32'd0, 8'd0);
        p.mode  = mode;
        p.f     = f;
        p.s     = s;
        p.h     = h;
        p.again = 1'b0;
        hx      = hex_decode(c);
        dig     = is_digit(c);
        unique case (mode) inside
            M_OPEN: begin
                if (c == CH_LPAREN) begin
                    p.mode = M_LIST;
                end else begin
                    p.emit = 1'b1;
                    p.res  = mk_result(K_NO_LIST, 32'd0, 32'd0, 8'd0);
                    p.mode = M_DONE;
                end
            end
            M_LIST: begin
                if (c == CH_RPAREN) begin
                    p.emit = 1'b1;
                    p.res  = mk_result(K_CLOSED, 32'd0, 32'd0, 8'd0);
                    p.mode = M_DONE;
                end else if (dig) begin
                    p.f    = VW'(c[3:0]);
                    p.mode = M_N1D;
                end else if (c == CH_QUOTE) begin
                    p.mode = M_STR;
                end else begin
                    p.emit = 1'b1;
                    p.res  = mk_result(K_BAILED, 32'd0, 32'd0, 8'd0);
                    p.mode = M_DONE;
                end
            end
            M_N1D, M_N1S: begin
                if (mode == M_N1D && dig) begin
                    p.f = mul10_add(f, c);
                end else if (mode == M_N1D && (c == CH_COMMA || c == CH_SPACE)) begin
                    p.mode = M_N1S;
                end else if (mode == M_N1S && c == CH_SPACE) begin
                    p.mode = M_N1S;
                end else if (c == CH_DASH) begin
                    p.s    = '0;
                    p.mode = M_N2D;
                end else begin
                    p.emit  = 1'b1;
                    p.res   = mk_result(K_NUMBER, 32'(f), 32'd0, 8'd0);
                    p.mode  = M_LIST;
                    p.again = 1'b1;
                end
            end
            M_N2D, M_N2S: begin
                if (mode == M_N2D && dig) begin
                    p.s = mul10_add(s, c);
                end else if (mode == M_N2D && (c == CH_COMMA || c == CH_SPACE)) begin
                    p.mode = M_N2S;
                end else if (mode == M_N2S && c == CH_SPACE) begin
                    p.mode = M_N2S;
                end else begin
                    p.emit  = 1'b1;
                    p.res   = mk_result(K_RANGE, 32'(f), 32'(s), 8'd0);
                    p.mode  = M_LIST;
                    p.again = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE) begin
                    p.emit = 1'b1;
                    p.res  = mk_result(K_STR_END, 32'd0, 32'd0, 8'd0);
                    p.mode = M_SAFT;
                end else if (c == CH_BACKSLASH) begin
                    p.mode = M_ESC;
                end else begin
                    p.emit = 1'b1;
                    p.res  = mk_result(K_BYTE, 32'd0, 32'd0, c);
                end
            end
            M_ESC: begin
                if (hx[4]) begin
                    p.h    = hx[3:0];
                    p.mode = M_HEX1;
                end else begin
                    p.emit  = 1'b1;
                    p.res   = mk_result(K_BYTE, 32'd0, 32'd0, CH_BACKSLASH);
                    p.mode  = M_STR;
                    p.again = 1'b1;
                end
            end
            M_HEX1: begin
                p.mode = M_STR;
                p.emit = 1'b1;
                if (hx[4]) begin
                    p.res = mk_result(K_BYTE, 32'd0, 32'd0, {h, hx[3:0]});
                end else begin
                    p.res   = mk_result(K_BYTE, 32'd0, 32'd0, {4'd0, h});
                    p.again = 1'b1;
                end
            end
            M_SAFT: begin
                if (c == CH_COMMA || c == CH_SPACE) begin
                    p.mode = M_SSP;
                end else begin
                    p.mode  = M_LIST;
                    p.again = 1'b1;
                end
            end
            M_SSP: begin
                if (c != CH_SPACE) begin
                    p.mode  = M_LIST;
                    p.again = 1'b1;
                end
            end
            default: begin
                p.mode = mode;
            end
        endcase
        return p;
    endfunction

    // Dispatch the character, and once more where the first dispatch hands it on.
    always_comb
    begin
        p1 = run_pass(mode_reg, item.ch, first_reg, second_reg, held_reg);
        if (p1.again) begin
            p2 = run_pass(p1.mode, item.ch, p1.f, p1.s, p1.h);
        end else begin
            p2      = p1;
            p2.emit = 1'b0;
        end
    end

    // Next state: the line end returns the parser to its reset state.
    always_comb
    begin
        if (item.line_end) begin
            mode_next   = M_OPEN;
            first_next  = '0;
            second_next = '0;
            held_next   = 4'd0;
        end else begin
            mode_next   = p2.mode;
            first_next  = p2.f;
            second_next = p2.s;
            held_next   = p2.h;
        end
    end

    // Outputs: collect the results of both dispatches, then those that close the line.
    always_comb
    begin
        bundle.res = '0;
        res_cnt    = 3'd0;
        if (p1.emit) begin
            bundle.res[res_cnt[1:0]] = p1.res;
            res_cnt = res_cnt + 3'd1;
        end
        if (p2.emit) begin
            bundle.res[res_cnt[1:0]] = p2.res;
            res_cnt = res_cnt + 3'd1;
        end
        if (item.line_end) begin
            unique case (p2.mode) inside
                M_N1D, M_N1S: begin
                    bundle.res[res_cnt[1:0]] = mk_result(K_NUMBER, 32'(p2.f), 32'd0, 8'd0);
                    res_cnt = res_cnt + 3'd1;
                end
                M_N2D, M_N2S: begin
                    bundle.res[res_cnt[1:0]] =
                        mk_result(K_RANGE, 32'(p2.f), 32'(p2.s), 8'd0);
                    res_cnt = res_cnt + 3'd1;
                end
                M_HEX1: begin
                    bundle.res[res_cnt[1:0]] = mk_result(K_BYTE, 32'd0, 32'd0, {4'd0, p2.h});
                    res_cnt = res_cnt + 3'd1;
                    bundle.res[res_cnt[1:0]] = mk_result(K_STR_END, 32'd0, 32'd0, 8'd0);
                    res_cnt = res_cnt + 3'd1;
                end
                M_STR, M_ESC: begin
                    bundle.res[res_cnt[1:0]] = mk_result(K_STR_END, 32'd0, 32'd0, 8'd0);
                    res_cnt = res_cnt + 3'd1;
                end
                default: begin
                    res_cnt = res_cnt;
                end
            endcase
            // Every open list reports the cut, after any pending node.
            if (p2.mode != M_OPEN && p2.mode != M_DONE) begin
                bundle.res[res_cnt[1:0]] = mk_result(K_CUT, 32'd0, 32'd0, 8'd0);
                res_cnt = res_cnt + 3'd1;
            end
        end
        bundle.last_idx = 2'(res_cnt - 3'd1);
        push_q          = accept && (res_cnt != 3'd0);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_OPEN;
            first_reg  <= '0;
            second_reg <= '0;
            held_reg   <= 4'd0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            held_reg   <= held_next;
        end
    end

endmodule

// ----- hdl/alfp_queue.sv -----
// Short queue of result bundles between the parser and the output stage.
`timescale 1ns / 1ps

module alfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  alfp_pkg::bundle_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output alfp_pkg::bundle_t rd_data,
    output logic              nonempty
);
    import alfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/alfp_back.sv -----
// Output stage: holds one bundle and hands its results out one transaction at a time.
`timescale 1ns / 1ps

module alfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  alfp_pkg::bundle_t   q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output alfp_pkg::out_item_t result
);
    import alfp_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       at_end;
    logic       advance;
    result_t    sel;

    assign at_end  = (idx_reg == cur_reg.last_idx);
    assign advance = !valid_reg || (pop && at_end);
    assign q_pop   = advance && q_nonempty;
    assign empty   = !valid_reg;

    // Present the current result of the held bundle.
    always_comb
    begin
        sel                = cur_reg.res[idx_reg];
        result.kind        = sel.kind;
        result.first_value = sel.first_value;
        result.last_value  = sel.last_value;
        result.string_byte = sel.string_byte;
        result.last        = at_end;
    end

    // Step through the bundle, loading the next one as the last result leaves.
    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (advance) begin
            cur_next   = q_data;
            valid_next = q_nonempty;
            idx_next   = 2'd0;
        end else if (pop) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Held bundle payload needs no reset.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ----- hdl/alfp_checker.sv -----
// Port-level checks for the list field parser, bound to its top level.
`timescale 1ns / 1ps

module alfp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input alfp_pkg::out_item_t result
);
    import alfp_pkg::*;

    // A waiting result that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before it was taken");

    // A list status always closes the results of its character.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == K_CLOSED || result.kind == K_CUT ||
                    result.kind == K_BAILED || result.kind == K_NO_LIST))
        |-> result.last)
        else $error("list status not flagged as final result");

    // Only numbers and ranges carry values, and only ranges carry a last value.
    a_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != K_RANGE) |->
        (result.last_value == 32'd0 &&
         (result.kind == K_NUMBER || result.first_value == 32'd0)))
        else $error("value fields set on a result that carries none");

    // Only string bytes carry a byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != K_BYTE) |-> (result.string_byte == 8'd0))
        else $error("string byte set on a result that is not a string byte");

endmodule

bind at_list_field_parser alfp_checker u_alfp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
